[hdl/gif_block_stream_parser_top_assert.svh]
// Assertion macros for the GIF block stream parser.
// Used by the front, queue and back modules; depends on nothing else.
`ifndef GIF_BLOCK_STREAM_PARSER_TOP_ASSERT_SVH
`define GIF_BLOCK_STREAM_PARSER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GBS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GBS_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[hdl/gbsp_pkg.sv]
// Package for the GIF block stream parser: result kinds, parse states and
// the request types passed between front, queue and back. No dependencies.
package gbsp_pkg;

    typedef enum logic [4:0] {
        K_HDR = 5'd0, K_SW = 5'd1, K_SH = 5'd2, K_SFLAGS = 5'd3, K_BG = 5'd4,
        K_ASPECT = 5'd5, K_GCOLOR = 5'd6, K_GCE = 5'd7, K_APPBYTE = 5'd8,
        K_LOOP = 5'd9, K_LEFT = 5'd10, K_TOP = 5'd11, K_WIDTH = 5'd12,
        K_HEIGHT = 5'd13, K_IFLAGS = 5'd14, K_LCOLOR = 5'd15,
        K_MINCODE = 5'd16, K_DATA = 5'd17, K_FRAMEEND = 5'd18,
        K_TRAILER = 5'd19
    } kind_t;

    typedef enum logic [3:0] {
        S_HDR, S_LSD, S_GCT, S_TOP, S_LABEL, S_GCE, S_APP, S_LOOP,
        S_SKSZ, S_SKDAT, S_IMG, S_LCT, S_MIN, S_DSZ, S_DDAT, S_DONE
    } pstate_t;

    localparam logic [7:0] BYTE_TRAILER = 8'h3B;
    localparam logic [7:0] BYTE_EXT     = 8'h21;
    localparam logic [7:0] BYTE_GCE     = 8'hF9;
    localparam logic [7:0] BYTE_APP     = 8'hFF;
    localparam logic [7:0] BYTE_IMAGE   = 8'h2C;
    localparam int QUEUE_DEPTH = 2;

    // One result request as produced by the front part.
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] value;
        logic [7:0]  index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        table_present;
        logic        table_sorted;
        logic [2:0]  size_code;
        logic [2:0]  three_bit_field;
        logic        flag_bit;
        logic        last;
    } result_t;

    // Identifier of the looping application extension, one byte per position.
    function automatic logic [7:0] loop_ident(input logic [3:0] pos);
        logic [7:0] r;
        begin
            unique case (pos)
                4'd0: r = 8'h4E;
                4'd1: r = 8'h45;
                4'd2: r = 8'h54;
                4'd3: r = 8'h53;
                4'd4: r = 8'h43;
                4'd5: r = 8'h41;
                4'd6: r = 8'h50;
                4'd7: r = 8'h45;
                4'd8: r = 8'h32;
                4'd9: r = 8'h2E;
                4'd10: r = 8'h30;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

endpackage

[hdl/gbsp_front.sv]
// Front of the GIF block stream parser: walks the block structure one byte a
// cycle while in_valid is high; builds result requests. Depends on gbsp_pkg.
`include "gif_block_stream_parser_top_assert.svh"
module gbsp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        data_byte,
    input  logic              start_of_file,
    output logic              req_valid,
    output gbsp_pkg::result_t req
);
    import gbsp_pkg::*;

    pstate_t     state_reg, state_next, st;
    logic [3:0]  pos_reg, pos_next, pos;
    logic [7:0]  sub_reg, sub_next;
    logic [8:0]  pal_reg, pal_next;
    logic [7:0]  ent_reg, ent_next;
    logic [1:0]  phase_reg, phase_next, ph;
    logic [7:0]  low_reg, low_next, lowv;
    logic [15:0] rg_reg, rg_next, rgv;
    logic [3:0]  tf_reg, tf_next, tf;
    logic        idm_reg, idm_next, idm;
    logic [19:0] cf_reg, cf_next, cf;
    logic [8:0]  pal;
    logic [7:0]  ent, sub;
    logic [15:0] word;
    logic [3:0]  apos;
    logic        emit;
    result_t     r;
    logic [7:0]  b;

    assign b = data_byte;

    always_comb
    begin
        // Start of file behaves as a reset applied before the byte is parsed.
        st   = start_of_file ? S_HDR : state_reg;
        pos  = start_of_file ? 4'd0 : pos_reg;
        sub  = start_of_file ? 8'd0 : sub_reg;
        pal  = start_of_file ? 9'd0 : pal_reg;
        ent  = start_of_file ? 8'd0 : ent_reg;
        ph   = start_of_file ? 2'd0 : phase_reg;
        lowv = start_of_file ? 8'd0 : low_reg;
        rgv  = start_of_file ? 16'd0 : rg_reg;
        tf   = start_of_file ? 4'd0 : tf_reg;
        idm  = start_of_file ? 1'b1 : idm_reg;
        cf   = start_of_file ? 20'd0 : cf_reg;
        word = {b, lowv};
        apos = (pos > 4'd11) ? 4'd11 : pos;

        state_next = st; pos_next = pos; sub_next = sub; pal_next = pal;
        ent_next = ent; phase_next = ph; low_next = lowv; rg_next = rgv;
        tf_next = tf; idm_next = idm; cf_next = cf;
        emit = 1'b0;
        r = '0;

        unique case (st)
            S_HDR:
            begin
                emit = 1'b1; r.kind = K_HDR; r.value = {8'd0, b};
                r.index = {4'd0, pos};
                if (pos >= 4'd5)
                begin
                    state_next = S_LSD; pos_next = 4'd0;
                end
                else pos_next = pos + 4'd1;
            end
            S_LSD:
            begin
                pos_next = pos + 4'd1;
                priority case (pos)
                    4'd0, 4'd2: low_next = b;
                    4'd1: begin emit = 1'b1; r.kind = K_SW; r.value = word; end
                    4'd3: begin emit = 1'b1; r.kind = K_SH; r.value = word; end
                    4'd4:
                    begin
                        emit = 1'b1; r.kind = K_SFLAGS; r.value = {8'd0, b};
                        r.table_present = b[7]; r.size_code = b[2:0];
                        r.table_sorted = b[3]; r.three_bit_field = b[6:4];
                        tf_next = {b[7], b[2:0]};
                    end
                    4'd5: begin emit = 1'b1; r.kind = K_BG; r.value = {8'd0, b}; end
                    default:
                    begin
                        emit = 1'b1; r.kind = K_ASPECT; r.value = {8'd0, b};
                        pos_next = 4'd0;
                        if (tf[3])
                        begin
                            state_next = S_GCT;
                            pal_next = 9'd2 << tf[2:0];
                            ent_next = 8'd0; phase_next = 2'd0;
                        end
                        else state_next = S_TOP;
                    end
                endcase
            end
            S_GCT, S_LCT:
            begin
                priority case (ph)
                    2'd0: begin rg_next = {b, 8'd0}; phase_next = 2'd1; end
                    2'd1: begin rg_next = {rgv[15:8], b}; phase_next = 2'd2; end
                    default:
                    begin
                        emit = 1'b1;
                        r.kind = (st == S_GCT) ? K_GCOLOR : K_LCOLOR;
                        r.index = ent; r.red = rgv[15:8]; r.green = rgv[7:0];
                        r.blue = b; r.last = (pal <= 9'd1);
                        phase_next = 2'd0; ent_next = ent + 8'd1;
                        if (pal <= 9'd1)
                        begin
                            pal_next = 9'd0;
                            state_next = (st == S_GCT) ? S_TOP : S_MIN;
                        end
                        else pal_next = pal - 9'd1;
                    end
                endcase
            end
            S_TOP:
            begin
                pos_next = 4'd0;
                if (b == BYTE_TRAILER)
                begin
                    emit = 1'b1; r.kind = K_TRAILER; r.value = {8'd0, b};
                    state_next = S_DONE;
                end
                else if (b == BYTE_EXT) state_next = S_LABEL;
                else if (b == BYTE_IMAGE) state_next = S_IMG;
            end
            S_LABEL:
            begin
                pos_next = 4'd0;
                if (b == BYTE_GCE) state_next = S_GCE;
                else if (b == BYTE_APP)
                begin
                    state_next = S_APP; idm_next = 1'b1;
                end
                else state_next = S_SKSZ;
            end
            S_GCE:
            begin
                pos_next = pos + 4'd1;
                priority case (pos)
                    4'd0: ;
                    4'd1: cf_next = {b[4:2], b[0], 16'd0};
                    4'd2: low_next = b;
                    4'd3: cf_next = {cf[19:16], word};
                    4'd4:
                    begin
                        emit = 1'b1; r.kind = K_GCE; r.value = cf[15:0];
                        r.index = b; r.three_bit_field = cf[19:17];
                        r.flag_bit = cf[16];
                    end
                    default: begin pos_next = 4'd0; state_next = S_TOP; end
                endcase
            end
            S_APP:
            begin
                if (pos == 4'd0) pos_next = 4'd1;
                else
                begin
                    emit = 1'b1; r.kind = K_APPBYTE; r.value = {8'd0, b};
                    r.index = {4'd0, apos - 4'd1};
                    r.flag_bit = idm && (b == loop_ident(apos - 4'd1));
                    idm_next = r.flag_bit;
                    if (apos >= 4'd11)
                    begin
                        pos_next = 4'd0;
                        state_next = r.flag_bit ? S_LOOP : S_SKSZ;
                    end
                    else pos_next = apos + 4'd1;
                end
            end
            S_LOOP:
            begin
                pos_next = pos + 4'd1;
                if (pos == 4'd2) low_next = b;
                else if (pos == 4'd3)
                begin
                    emit = 1'b1; r.kind = K_LOOP; r.value = word;
                end
                else if (pos > 4'd3)
                begin
                    pos_next = 4'd0; state_next = S_TOP;
                end
            end
            S_SKSZ:
            begin
                if (b == 8'd0) state_next = S_TOP;
                else begin sub_next = b; state_next = S_SKDAT; end
            end
            S_SKDAT:
            begin
                if (sub <= 8'd1) begin sub_next = 8'd0; state_next = S_SKSZ; end
                else sub_next = sub - 8'd1;
            end
            S_IMG:
            begin
                pos_next = pos + 4'd1;
                if (pos < 4'd8)
                begin
                    if (!pos[0]) low_next = b;
                    else
                    begin
                        emit = 1'b1; r.kind = 5'(K_LEFT) + {3'd0, pos[2:1]};
                        r.value = word;
                    end
                end
                else
                begin
                    emit = 1'b1; r.kind = K_IFLAGS; r.value = {8'd0, b};
                    r.table_present = b[7]; r.size_code = b[2:0];
                    r.table_sorted = b[5]; r.flag_bit = b[6];
                    tf_next = {b[7], b[2:0]}; pos_next = 4'd0;
                    if (b[7])
                    begin
                        state_next = S_LCT; pal_next = 9'd2 << b[2:0];
                        ent_next = 8'd0; phase_next = 2'd0;
                    end
                    else state_next = S_MIN;
                end
            end
            S_MIN:
            begin
                emit = 1'b1; r.kind = K_MINCODE; r.value = {8'd0, b};
                state_next = S_DSZ;
            end
            S_DSZ:
            begin
                if (b == 8'd0)
                begin
                    emit = 1'b1; r.kind = K_FRAMEEND; state_next = S_TOP;
                end
                else begin sub_next = b; state_next = S_DDAT; end
            end
            S_DDAT:
            begin
                emit = 1'b1; r.kind = K_DATA; r.value = {8'd0, b};
                if (sub <= 8'd1) begin sub_next = 8'd0; state_next = S_DSZ; end
                else sub_next = sub - 8'd1;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    assign req_valid = in_valid && emit;
    assign req = r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HDR; pos_reg <= '0; sub_reg <= '0; pal_reg <= '0;
            ent_reg <= '0; phase_reg <= '0; low_reg <= '0; rg_reg <= '0;
            tf_reg <= '0; idm_reg <= 1'b1; cf_reg <= '0;
        end
        else if (in_valid)
        begin
            state_reg <= state_next; pos_reg <= pos_next; sub_reg <= sub_next;
            pal_reg <= pal_next; ent_reg <= ent_next; phase_reg <= phase_next;
            low_reg <= low_next; rg_reg <= rg_next; tf_reg <= tf_next;
            idm_reg <= idm_next; cf_reg <= cf_next;
        end
    end

    `GBS_ASSERT_IMP(a_pal_phase, clk, rst_n, state_reg != S_GCT && state_reg != S_LCT
        || phase_reg != 2'd3, 1'b1)
    `GBS_ASSERT_NXT(a_done_holds, clk, rst_n,
        state_reg == S_DONE && !(in_valid && start_of_file), state_reg == S_DONE)
    `GBS_ASSERT_IMP(a_done_quiet, clk, rst_n, state_reg == S_DONE && !start_of_file,
        !req_valid)

endmodule

[hdl/gbsp_queue.sv]
// Short request queue between front and back of the parser.
// Depends on gbsp_pkg.
`include "gif_block_stream_parser_top_assert.svh"
module gbsp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  gbsp_pkg::result_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output logic              rd_valid,
    output gbsp_pkg::result_t rd_data
);
    import gbsp_pkg::*;

    result_t    mem_reg [QUEUE_DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign full     = (cnt_reg == 2'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;
    assign cnt_next = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};

    always_ff @(posedge clk)
    begin
        if (do_wr) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr) wp_reg <= ~wp_reg;
            if (do_rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_next;
        end
    end

    `GBS_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= 2'(QUEUE_DEPTH))
    `GBS_ASSERT_IMP(a_ptr_match, clk, rst_n, cnt_reg == 2'd0 || cnt_reg == 2'd2,
        wp_reg == rp_reg)
    `GBS_ASSERT_NXT(a_count_step, clk, rst_n, do_wr && !do_rd, cnt_reg != 2'd0)

endmodule

[hdl/gbsp_back.sv]
// Back part of the parser: output register stage that presents results
// on the pop side. Depends on gbsp_pkg.
`include "gif_block_stream_parser_top_assert.svh"
module gbsp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  gbsp_pkg::result_t q_data,
    output logic              q_take,
    input  logic              pop,
    output logic              empty,
    output gbsp_pkg::result_t res
);
    import gbsp_pkg::*;

    logic    full_reg;
    result_t res_reg;

    assign empty  = !full_reg;
    assign q_take = q_valid && (!full_reg || pop);
    assign res    = res_reg;

    always_ff @(posedge clk)
    begin
        if (q_take) res_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) full_reg <= 1'b0;
        else if (q_take) full_reg <= 1'b1;
        else if (pop) full_reg <= 1'b0;
    end

    `GBS_ASSERT_NXT(a_hold, clk, rst_n, full_reg && !pop, full_reg && $stable(res_reg))
    `GBS_ASSERT_NXT(a_fill, clk, rst_n, q_take, full_reg)
    `GBS_ASSERT_IMP(a_kind_ok, clk, rst_n, full_reg, res_reg.kind <= K_TRAILER)

endmodule

[hdl/gif_block_stream_parser_top.sv]
// Top level of the GIF block stream parser.
// Depends on gbsp_pkg, gbsp_front, gbsp_queue and gbsp_back.
//
// Usage: bytes of a GIF file enter on the push side (data_byte,
// start_of_file); an item is accepted when push is high and full is low.
// A byte with start_of_file high begins a new file and clears all parse state.
// Each byte causes at most one tagged result (kind, value, index, colours,
// flags), presented on the pop side while empty is low and taken when pop
// is high. Colour table entries appear once their blue byte arrives.
// The block takes one byte every cycle while full is low. On its way out a
// result passes the front part, which classifies the byte in the cycle of
// acceptance, a two-entry request queue, which holds it, and the output
// register, which presents it. When the receiver stalls, the queue and output
// register fill; full then rises and bytes are held off until pop drains a
// result. Full looks only at the queue, so bytes that would cause no result
// are held off as well while it is high.
// After reset the block expects the header and all queues are empty.
module gif_block_stream_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       start_of_file,
    output logic       empty,
    input  logic       pop,
    output logic [4:0] kind,
    output logic [15:0] value,
    output logic [7:0] index,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic       table_present,
    output logic       table_sorted,
    output logic [2:0] size_code,
    output logic [2:0] three_bit_field,
    output logic       flag_bit,
    output logic       last
);
    import gbsp_pkg::*;

    logic    accept, req_valid, q_full, q_valid, q_take;
    result_t req, q_data, res;

    // The queue full flag stalls input; an accepted byte's request fits.
    assign full   = q_full;
    assign accept = push && !q_full;

    gbsp_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .data_byte(data_byte),
        .start_of_file(start_of_file), .req_valid(req_valid), .req(req)
    );

    gbsp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(req_valid), .wr_data(req),
        .full(q_full), .rd_en(q_take), .rd_valid(q_valid), .rd_data(q_data)
    );

    gbsp_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
        .q_take(q_take), .pop(pop), .empty(empty), .res(res)
    );

    assign kind = res.kind;
    assign value = res.value;
    assign index = res.index;
    assign red = res.red;
    assign green = res.green;
    assign blue = res.blue;
    assign table_present = res.table_present;
    assign table_sorted = res.table_sorted;
    assign size_code = res.size_code;
    assign three_bit_field = res.three_bit_field;
    assign flag_bit = res.flag_bit;
    assign last = res.last;

endmodule

[verif/tb.sv]
// Self-checking testbench for the GIF block stream parser top level.
// Depends on gbsp_pkg and gif_block_stream_parser_top; drives GIF byte streams
// and compares every result request with a predictor held in this file.
module tb;
    import gbsp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        start_of_file;
    logic        empty;
    logic        pop = 1'b0;
    logic [4:0]  kind;
    logic [15:0] value;
    logic [7:0]  index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        table_present;
    logic        table_sorted;
    logic [2:0]  size_code;
    logic [2:0]  three_bit_field;
    logic        flag_bit;
    logic        last;

    gif_block_stream_parser_top i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_byte(data_byte), .start_of_file(start_of_file),
        .empty(empty), .pop(pop), .kind(kind), .value(value), .index(index),
        .red(red), .green(green), .blue(blue), .table_present(table_present),
        .table_sorted(table_sorted), .size_code(size_code),
        .three_bit_field(three_bit_field), .flag_bit(flag_bit), .last(last)
    );

    // The clock runs with a period of four time units.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Predictor state: a private copy of the parser's bookkeeping.
    pstate_t     gp_state;
    logic [3:0]  gp_pos;
    logic [7:0]  gp_sub_left;
    logic [8:0]  gp_pal_left;
    logic [7:0]  gp_entry;
    logic [1:0]  gp_phase;
    logic [7:0]  gp_low;
    logic [15:0] gp_rg;
    logic [3:0]  gp_tflags;
    logic        gp_ident_ok;
    logic [15:0] gp_delay;
    logic        gp_transp;
    logic [2:0]  gp_disposal;

    result_t     field_queue[$];
    int          fail_count = 0;
    int          idle_pct;
    bit          hold_pop;
    int          stall_cycles = 0;
    bit          ending;
    int          bytes_sent;

    localparam int  LIMIT_CYCLES = 4000;
    localparam int  HOLD_CYCLES  = 60;

    function automatic logic [7:0] ident_byte(input int p);
        case (p)
            0: return 8'h4E;
            1: return 8'h45;
            2: return 8'h54;
            3: return 8'h53;
            4: return 8'h43;
            5: return 8'h41;
            6: return 8'h50;
            7: return 8'h45;
            8: return 8'h32;
            9: return 8'h2E;
            default: return 8'h30;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255, 0));
    endfunction

    task automatic clear_parser();
        gp_state = S_HDR;
        gp_pos = '0;
        gp_sub_left = '0;
        gp_pal_left = '0;
        gp_entry = '0;
        gp_phase = '0;
        gp_low = '0;
        gp_rg = '0;
        gp_tflags = '0;
        gp_ident_ok = 1'b1;
        gp_delay = '0;
        gp_transp = 1'b0;
        gp_disposal = '0;
    endtask

    function automatic result_t field(input kind_t k, input logic [15:0] v,
                                      input logic [7:0] ix);
        result_t r;
        r = '0;
        r.kind = k;
        r.value = v;
        r.index = ix;
        return r;
    endfunction

    // Appends one predicted result to the tail of the queue.
    task automatic queue_field(input result_t r);
        field_queue.insert(field_queue.size(), r);
    endtask

    task automatic begin_palette(input pstate_t nxt);
        gp_state = nxt;
        gp_pal_left = 9'd2 << gp_tflags[2:0];
        gp_entry = '0;
        gp_phase = '0;
    endtask

    // A palette entry is complete on its blue byte.
    task automatic palette_step(input logic [7:0] b, input kind_t k,
                                input pstate_t after);
        result_t r;
        if (gp_phase == 2'd0)
        begin
            gp_rg = {b, 8'h00};
            gp_phase = 2'd1;
        end
        else if (gp_phase == 2'd1)
        begin
            gp_rg[7:0] = b;
            gp_phase = 2'd2;
        end
        else
        begin
            r = field(k, 16'd0, gp_entry);
            r.red = gp_rg[15:8];
            r.green = gp_rg[7:0];
            r.blue = b;
            r.last = (gp_pal_left <= 9'd1);
            queue_field(r);
            gp_phase = 2'd0;
            gp_entry = gp_entry + 8'd1;
            if (gp_pal_left <= 9'd1)
            begin
                gp_pal_left = '0;
                gp_state = after;
            end
            else
                gp_pal_left = gp_pal_left - 9'd1;
        end
    endtask

    // Works out the result, if any, that one accepted byte causes.
    task automatic parse_byte(input logic [7:0] b, input logic sof);
        result_t     r;
        logic [3:0]  p;
        logic [15:0] w;
        if (sof)
            clear_parser();
        p = gp_pos;
        w = {b, gp_low};
        case (gp_state)
            S_HDR:
            begin
                queue_field(field(K_HDR, {8'h00, b}, {4'h0, p}));
                if (p >= 4'd5)
                begin
                    gp_state = S_LSD;
                    gp_pos = '0;
                end
                else
                    gp_pos = p + 4'd1;
            end
            S_LSD:
            begin
                gp_pos = p + 4'd1;
                case (p)
                    4'd0, 4'd2: gp_low = b;
                    4'd1: queue_field(field(K_SW, w, 8'd0));
                    4'd3: queue_field(field(K_SH, w, 8'd0));
                    4'd4:
                    begin
                        r = field(K_SFLAGS, {8'h00, b}, 8'd0);
                        r.table_present = b[7];
                        r.size_code = b[2:0];
                        r.table_sorted = b[3];
                        r.three_bit_field = b[6:4];
                        queue_field(r);
                        gp_tflags = {b[7], b[2:0]};
                    end
                    4'd5: queue_field(field(K_BG, {8'h00, b}, 8'd0));
                    default:
                    begin
                        queue_field(field(K_ASPECT, {8'h00, b}, 8'd0));
                        gp_pos = '0;
                        if (gp_tflags[3])
                            begin_palette(S_GCT);
                        else
                            gp_state = S_TOP;
                    end
                endcase
            end
            S_GCT: palette_step(b, K_GCOLOR, S_TOP);
            S_TOP:
            begin
                gp_pos = '0;
                if (b == BYTE_TRAILER)
                begin
                    queue_field(field(K_TRAILER, {8'h00, b}, 8'd0));
                    gp_state = S_DONE;
                end
                else if (b == BYTE_EXT)
                    gp_state = S_LABEL;
                else if (b == BYTE_IMAGE)
                    gp_state = S_IMG;
            end
            S_LABEL:
            begin
                gp_pos = '0;
                if (b == BYTE_GCE)
                    gp_state = S_GCE;
                else if (b == BYTE_APP)
                begin
                    gp_state = S_APP;
                    gp_ident_ok = 1'b1;
                end
                else
                    gp_state = S_SKSZ;
            end
            S_GCE:
            begin
                gp_pos = p + 4'd1;
                case (p)
                    4'd0: ;
                    4'd1:
                    begin
                        gp_disposal = b[4:2];
                        gp_transp = b[0];
                        gp_delay = '0;
                    end
                    4'd2: gp_low = b;
                    4'd3: gp_delay = w;
                    4'd4:
                    begin
                        r = field(K_GCE, gp_delay, b);
                        r.three_bit_field = gp_disposal;
                        r.flag_bit = gp_transp;
                        queue_field(r);
                    end
                    default:
                    begin
                        gp_pos = '0;
                        gp_state = S_TOP;
                    end
                endcase
            end
            S_APP:
            begin
                if (p == 4'd0)
                    gp_pos = 4'd1;
                else
                begin
                    if (p > 4'd11)
                        p = 4'd11;
                    if (b != ident_byte(int'(p) - 1))
                        gp_ident_ok = 1'b0;
                    r = field(K_APPBYTE, {8'h00, b}, {4'h0, p - 4'd1});
                    r.flag_bit = gp_ident_ok;
                    queue_field(r);
                    if (p >= 4'd11)
                    begin
                        gp_pos = '0;
                        gp_state = gp_ident_ok ? S_LOOP : S_SKSZ;
                    end
                    else
                        gp_pos = p + 4'd1;
                end
            end
            S_LOOP:
            begin
                gp_pos = p + 4'd1;
                if (p == 4'd2)
                    gp_low = b;
                else if (p == 4'd3)
                    queue_field(field(K_LOOP, w, 8'd0));
                else if (p > 4'd3)
                begin
                    gp_pos = '0;
                    gp_state = S_TOP;
                end
            end
            S_SKSZ:
            begin
                if (b == 8'd0)
                    gp_state = S_TOP;
                else
                begin
                    gp_sub_left = b;
                    gp_state = S_SKDAT;
                end
            end
            S_SKDAT:
            begin
                if (gp_sub_left <= 8'd1)
                begin
                    gp_sub_left = '0;
                    gp_state = S_SKSZ;
                end
                else
                    gp_sub_left = gp_sub_left - 8'd1;
            end
            S_IMG:
            begin
                gp_pos = p + 4'd1;
                if (p < 4'd8)
                begin
                    if (!p[0])
                        gp_low = b;
                    else
                        queue_field(field(kind_t'(5'd10 + {2'd0, p[3:1]}), w, 8'd0));
                end
                else
                begin
                    r = field(K_IFLAGS, {8'h00, b}, 8'd0);
                    r.table_present = b[7];
                    r.size_code = b[2:0];
                    r.table_sorted = b[5];
                    r.flag_bit = b[6];
                    queue_field(r);
                    gp_tflags = {b[7], b[2:0]};
                    gp_pos = '0;
                    if (gp_tflags[3])
                        begin_palette(S_LCT);
                    else
                        gp_state = S_MIN;
                end
            end
            S_LCT: palette_step(b, K_LCOLOR, S_MIN);
            S_MIN:
            begin
                queue_field(field(K_MINCODE, {8'h00, b}, 8'd0));
                gp_state = S_DSZ;
            end
            S_DSZ:
            begin
                if (b == 8'd0)
                begin
                    queue_field(field(K_FRAMEEND, 16'd0, 8'd0));
                    gp_state = S_TOP;
                end
                else
                begin
                    gp_sub_left = b;
                    gp_state = S_DDAT;
                end
            end
            S_DDAT:
            begin
                queue_field(field(K_DATA, {8'h00, b}, 8'd0));
                if (gp_sub_left <= 8'd1)
                begin
                    gp_sub_left = '0;
                    gp_state = S_DSZ;
                end
                else
                    gp_sub_left = gp_sub_left - 8'd1;
            end
            default: ;
        endcase
    endtask

    // Offers one byte, idling at random first, and waits until it is taken.
    // The prediction is made at the edge of acceptance. Push is left high
    // afterwards; the next call or the end of the run lowers it.
    task automatic send_byte(input logic [7:0] b, input logic sof);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        start_of_file <= sof;
        do
            @(posedge clk);
        while (full);
        parse_byte(b, sof);
        bytes_sent++;
    endtask

    task automatic send_word(input logic [15:0] w);
        send_byte(w[7:0], 1'b0);
        send_byte(w[15:8], 1'b0);
    endtask

    // Header and logical screen descriptor; flags choose the global table.
    task automatic send_head(input logic [7:0] flags);
        send_byte(8'h47, 1'b1);
        send_byte(8'h49, 1'b0);
        send_byte(8'h46, 1'b0);
        for (int i = 0; i < 3; i++)
            send_byte(rand_byte(), 1'b0);
        send_word(16'($urandom));
        send_word(16'($urandom));
        send_byte(flags, 1'b0);
        send_byte(rand_byte(), 1'b0);
        send_byte(rand_byte(), 1'b0);
        if (flags[7])
            for (int i = 0; i < (6 << flags[2:0]); i++)
                send_byte(rand_byte(), 1'b0);
    endtask

    task automatic send_gce();
        send_byte(BYTE_EXT, 1'b0);
        send_byte(BYTE_GCE, 1'b0);
        send_byte(rand_byte(), 1'b0);
        send_byte(rand_byte(), 1'b0);
        send_word(16'($urandom));
        send_byte(rand_byte(), 1'b0);
        send_byte(rand_byte(), 1'b0);
    endtask

    // Looping extension when faithful; otherwise one identifier byte is
    // spoiled and the sub-blocks that follow are skipped.
    task automatic send_app(input bit faithful);
        int bad;
        int n;
        bad = faithful ? -1 : int'($urandom_range(10, 0));
        send_byte(BYTE_EXT, 1'b0);
        send_byte(BYTE_APP, 1'b0);
        send_byte(8'd11, 1'b0);
        for (int i = 0; i < 11; i++)
            send_byte(i == bad ? ident_byte(i) ^ 8'h01 : ident_byte(i), 1'b0);
        if (faithful)
        begin
            send_byte(8'd3, 1'b0);
            send_byte(8'd1, 1'b0);
            send_word(16'($urandom));
            send_byte(rand_byte(), 1'b0);
        end
        else
        begin
            n = int'($urandom_range(4, 1));
            send_byte(8'(n), 1'b0);
            for (int i = 0; i < n; i++)
                send_byte(rand_byte(), 1'b0);
            send_byte(8'd0, 1'b0);
        end
    endtask

    task automatic send_unknown_ext();
        int n;
        logic [7:0] lbl;
        lbl = rand_byte();
        if (lbl == BYTE_GCE || lbl == BYTE_APP)
            lbl = 8'h01;
        send_byte(BYTE_EXT, 1'b0);
        send_byte(lbl, 1'b0);
        for (int k = 0; k < $urandom_range(2, 0); k++)
        begin
            n = int'($urandom_range(5, 1));
            send_byte(8'(n), 1'b0);
            for (int i = 0; i < n; i++)
                send_byte(rand_byte(), 1'b0);
        end
        send_byte(8'd0, 1'b0);
    endtask

    // Image descriptor, optional local table and data sub-blocks.
    task automatic send_image(input logic [7:0] flags, input int blocks);
        int n;
        send_byte(BYTE_IMAGE, 1'b0);
        for (int i = 0; i < 4; i++)
            send_word(16'($urandom));
        send_byte(flags, 1'b0);
        if (flags[7])
            for (int i = 0; i < (6 << flags[2:0]); i++)
                send_byte(rand_byte(), 1'b0);
        send_byte(rand_byte(), 1'b0);
        for (int k = 0; k < blocks; k++)
        begin
            n = int'($urandom_range(6, 1));
            send_byte(8'(n), 1'b0);
            for (int i = 0; i < n; i++)
                send_byte(rand_byte(), 1'b0);
        end
        send_byte(8'd0, 1'b0);
    endtask

    // Small tables in most files; the sorted and resolution bits random.
    function automatic logic [7:0] table_flags(input bit big);
        logic [7:0] f;
        f = rand_byte();
        if (!big)
            f[2:0] = 3'($urandom_range(2, 0));
        return f;
    endfunction

    task automatic test_extremes();
        // Largest global table, all-ones flags, looping extension, then
        // an interlaced image with a sorted local table, a trailer and
        // bytes ignored after it.
        send_head(8'hFF);
        send_app(1'b1);
        send_gce();
        send_image(8'hE2, 1);
        send_byte(BYTE_TRAILER, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // No tables, all-zero flags, stray bytes at top level, unknown
        // extension, spoilt identifier and an empty image.
        send_head(8'h00);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_unknown_ext();
        send_app(1'b0);
        send_image(8'h40, 0);
        send_byte(BYTE_TRAILER, 1'b0);
    endtask

    task automatic test_restart();
        // A new file starts part way through blocks of the old one.
        send_head(8'h80);
        send_byte(BYTE_EXT, 1'b0);
        send_byte(BYTE_APP, 1'b0);
        send_byte(8'd11, 1'b0);
        send_byte(8'h4E, 1'b0);
        send_head(8'h01);
        send_byte(BYTE_IMAGE, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h00, 1'b1);
        for (int i = 0; i < 8; i++)
            send_byte(rand_byte(), 1'b0);
    endtask

    // Random files until the running byte count reaches the goal.
    task automatic test_random_files(input int byte_goal);
        int pick;
        while (bytes_sent < byte_goal)
        begin
            send_head(table_flags(1'b0));
            for (int b = 0; b < $urandom_range(6, 1); b++)
            begin
                pick = int'($urandom_range(9, 0));
                if (pick < 4)
                    send_image(table_flags(1'b0), int'($urandom_range(3, 0)));
                else if (pick < 6)
                    send_gce();
                else if (pick == 6)
                    send_app(1'($urandom_range(1, 0)));
                else if (pick == 7)
                    send_unknown_ext();
                else
                    send_byte(rand_byte(), $urandom_range(19, 0) == 0);
            end
            if ($urandom_range(3, 0) != 0)
                send_byte(BYTE_TRAILER, 1'b0);
        end
    endtask

    task automatic test_backpressure();
        // The receiver holds off while bytes keep coming, so full must rise.
        idle_pct = 0;
        hold_pop = 1'b1;
        send_head(8'h81);
        send_image(8'h00, 2);
        hold_pop = 1'b0;
        idle_pct = 18;
    endtask

    // Result checker and receiver idling.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (field_queue.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual kind %0d",
                             $time, kind);
                    fail_count++;
                end
                else
                begin
                    result_t want;
                    result_t got;
                    want = field_queue.pop_front();
                    got = {kind, value, index, red, green, blue, table_present,
                           table_sorted, size_code, three_bit_field, flag_bit, last};
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        fail_count++;
                    end
                end
            end
            if (hold_pop && stall_cycles < HOLD_CYCLES)
            begin
                stall_cycles++;
                pop <= 1'b0;
            end
            else
                pop <= (idle_pct == 0) || ($urandom_range(99, 0) >= idle_pct);
        end
    end

    // Watchdog: cycles in which neither side moves a request.
    int quiet = 0;
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n || ending)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        push = 1'b0;
        data_byte = '0;
        start_of_file = 1'b0;
        rst_n = 1'b0;
        idle_pct = 18;
        hold_pop = 1'b0;
        ending = 1'b0;
        bytes_sent = 0;
        clear_parser();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_restart();
        test_backpressure();
        test_random_files(1050);
        // A stretch with no idling on either side.
        idle_pct = 0;
        test_random_files(1180);
        idle_pct = 18;
        test_random_files(1260);
        push <= 1'b0;
        while (field_queue.size() != 0)
            @(posedge clk);
        ending = 1'b1;
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
